/* rtl/core/ght_pkg.sv */
// ght_pkg: shared types, constants and hash function for the generation hash table
// no dependencies
package ght_pkg;

	localparam int unsigned INDEX_BITS_DEF = 10;
	localparam int unsigned MAX_PROBES_DEF = 20;
	localparam logic [31:0] RESET_GEN      = 32'd3;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_TAS    = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch item
		logic hash;      // compute home slot
		logic rd;        // issue read of probe slot
		logic step;      // advance probe pointer
		logic wr;        // write entry at chosen slot
		logic clr_gen;   // advance generation
		logic done;      // present result
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic stop;      // probing ends at the slot just read
		logic cleared;   // clearing pass complete
	} sts_t;

	// first three rounds of the integer hash
	function automatic logic [31:0] hash_a(input logic [31:0] k);
		logic [31:0] h;
		h = (k + 32'h7ed55d16) + (k << 12);
		h = (h ^ 32'hc761c23c) ^ (h >> 19);
		h = (h + 32'h165667b1) + (h << 5);
		return h;
	endfunction

	// last three rounds
	function automatic logic [31:0] hash_b(input logic [31:0] k);
		logic [31:0] h;
		h = (k + 32'hd3a2646c) ^ (k << 9);
		h = (h + 32'hfd7046c5) + (h << 3);
		h = (h ^ 32'hb55a4f09) ^ (h >> 16);
		return h;
	endfunction

endpackage

/* rtl/core/ght_ctrl.sv */
// ght_ctrl: sequencer for hashing, probing, write-back and the reset clearing pass
// depends on ght_pkg
module ght_ctrl
	import ght_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy_in,
	input  sts_t sts,
	input  logic [1:0] mode,
	output ctl_t ctl,
	output logic busy
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_HASH1 = 7'b0000100,
		ST_HASH2 = 7'b0001000,
		ST_READ  = 7'b0010000,
		ST_EVAL  = 7'b0100000,
		ST_WRITE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.cleared) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					if (mode == MODE_CLEAR) state_d = ST_WRITE;
					else state_d = ST_HASH1;
				end
			end
			ST_HASH1: begin
				ctl.hash = 1'b1;
				state_d = ST_HASH2;
			end
			ST_HASH2: begin
				ctl.rd = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				if (sts.stop) state_d = ST_WRITE;
				else begin
					ctl.step = 1'b1;
					ctl.rd = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_WRITE: begin
				ctl.wr = 1'b1;
				ctl.done = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	// busy_in is the port-side copy of busy, used only for checking
`ifndef SYNTH
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !busy_in) else $error("load while busy");
	a_done_next_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |=> state_q == ST_IDLE) else $error("done not followed by idle");
	a_read_eval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_EVAL) else $error("read not evaluated");
`endif

endmodule

/* rtl/core/ght_dpath.sv */
// ght_dpath: slot memories, hash registers, probe pointer and result logic
// depends on ght_pkg
module ght_dpath
	import ght_pkg::*;
#(
	parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
	parameter int unsigned MAX_PROBES = MAX_PROBES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  logic [1:0]  mode,
	input  logic [31:0] key,
	input  logic [31:0] data_in,
	output sts_t        sts,
	output logic        done,
	output logic        status,
	output logic [31:0] found_value,
	output logic        is_different,
	output logic        is_stale
);

	localparam int unsigned DEPTH = 1 << INDEX_BITS;
	localparam int unsigned CW = $clog2(MAX_PROBES + 1);
	localparam logic [CW-1:0] MAXP = CW'(MAX_PROBES);

	// slot memories; tag 0 cannot be the reset generation, so the clearing
	// pass writes key, value and tag to zero
	logic [31:0] mem_key [DEPTH];
	logic [31:0] mem_val [DEPTH];
	logic [31:0] mem_gen [DEPTH];

	logic [1:0]  mode_q;
	logic [31:0] key_q, data_q, hash_q, gen_q;
	logic [INDEX_BITS-1:0] ptr_q, stop_q, fst_q, clr_q;
	logic        have_q, clr_busy_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] rk_q, rv_q, rg_q;

	logic cur, kmatch, empty, stop;
	logic [INDEX_BITS-1:0] wa;
	logic we, res;
	logic [31:0] hb;
	logic [INDEX_BITS-1:0] ra;

	assign cur    = (rg_q == gen_q);
	assign kmatch = (rk_q == key_q);
	assign empty  = (rk_q == 32'd0);
	assign sts.cleared = clr_busy_q && (clr_q == INDEX_BITS'(DEPTH - 1));

	// second half of the hash and the read address
	assign hb = hash_b(hash_q);
	assign ra = ctl.step ? ptr_q + 1'b1 : ptr_q;

	// probe end condition per mode
	always_comb begin
		if (mode_q == MODE_TAS)
			stop = (cnt_q == MAXP) || (ptr_q == stop_q) || empty || kmatch;
		else
			stop = (ptr_q == stop_q) || !cur || kmatch;
	end
	assign sts.stop = stop;

	// write decision at the final slot
	always_comb begin
		we = 1'b0;
		wa = ptr_q;
		res = 1'b0;
		case (mode_q)
			MODE_INSERT: begin
				we = !cur || kmatch;
				res = we;
			end
			MODE_LOOKUP: res = cur && kmatch;
			MODE_TAS: begin
				if (kmatch || empty) we = 1'b1;
				else if (have_q) begin
					we = 1'b1;
					wa = fst_q;
				end
				res = we;
			end
			default: res = 1'b1;
		endcase
	end

	// generation, clearing pass and done registers; item and probe registers follow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= RESET_GEN;
			clr_q <= '0;
			clr_busy_q <= 1'b1;
			done <= 1'b0;
		end else begin
			done <= ctl.done;
			if (clr_busy_q) clr_q <= clr_q + 1'b1;
			if (sts.cleared) clr_busy_q <= 1'b0;
			if (ctl.clr_gen || (ctl.wr && mode_q == MODE_CLEAR)) gen_q <= gen_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q <= mode;
			key_q <= key;
			data_q <= data_in;
			hash_q <= hash_a(key);
		end
		if (ctl.hash) begin
			ptr_q <= hb[INDEX_BITS-1:0];
			stop_q <= hb[INDEX_BITS-1:0] - 1'b1;
			cnt_q <= '0;
			have_q <= 1'b0;
		end
		if (ctl.step) begin
			if (!have_q && !cur) begin
				have_q <= 1'b1;
				fst_q <= ptr_q;
			end
			ptr_q <= ptr_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (ctl.done) begin
			status <= res;
			found_value <= (mode_q == MODE_LOOKUP && res) ? rv_q : 32'd0;
			is_different <= (mode_q == MODE_TAS) && kmatch && (rv_q != data_q);
			is_stale <= (mode_q == MODE_TAS) && kmatch && !cur;
		end
	end

	// memory read and write ports
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_key[clr_q] <= '0;
			mem_val[clr_q] <= '0;
			mem_gen[clr_q] <= '0;
		end else if (ctl.wr && we) begin
			mem_key[wa] <= key_q;
			mem_val[wa] <= data_q;
			mem_gen[wa] <= gen_q;
		end
		if (ctl.rd) begin
			rk_q <= mem_key[ra];
			rv_q <= mem_val[ra];
			rg_q <= mem_gen[ra];
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> cnt_q != MAXP || mode_q != MODE_TAS) else $error("probe limit passed");
	a_no_wr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !ctl.wr) else $error("write during clearing pass");
	a_lookup_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr && mode_q == MODE_LOOKUP |-> !we) else $error("lookup writes");
`endif

endmodule

/* rtl/core/generation_hash_table.sv */
// generation_hash_table: top level joining controller and datapath
// depends on ght_pkg, ght_ctrl, ght_dpath
//
// An item is taken when start is high and busy low; its result shows for one cycle with
// done. Clear advances the generation; other modes hash the key and then probe slot by
// slot, each probe being a registered read of the slot memories then a compare.
// Test-and-set probes at most MAX_PROBES slots past home; insert and lookup may walk up
// to 2^INDEX_BITS - 1 slots on a crowded table. After reset busy stays high while the
// clearing pass zeroes every slot. The receiver cannot stall: done is a plain strobe.
module generation_hash_table
	import ght_pkg::*;
#(
	parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
	parameter int unsigned MAX_PROBES = MAX_PROBES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] key,
	input  logic [31:0] data_in,
	output logic        done,
	output logic        status,
	output logic [31:0] found_value,
	output logic        is_different,
	output logic        is_stale
);

	ctl_t ctl;
	sts_t sts;

	ght_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy_in(busy), .sts(sts),
		.mode(mode), .ctl(ctl), .busy(busy)
	);

	ght_dpath #(.INDEX_BITS(INDEX_BITS), .MAX_PROBES(MAX_PROBES)) u_dpath (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .mode(mode), .key(key),
		.data_in(data_in), .sts(sts), .done(done), .status(status),
		.found_value(found_value), .is_different(is_different), .is_stale(is_stale)
	);

endmodule
